/* rtl/ladder_lowpass_filter_macros.svh */
// Assertion macros shared by the ladder low-pass filter RTL.
`ifndef LADDER_LOWPASS_FILTER_MACROS_SVH
`define LADDER_LOWPASS_FILTER_MACROS_SVH
`ifndef ASSERT_OFF
// Check that cons holds in the same cycle whenever ante holds.
`define LLF_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ladder_lowpass_filter: same-cycle check failed");
// Check that cons holds in the cycle after ante.
`define LLF_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ladder_lowpass_filter: next-cycle check failed");
`else
`define LLF_ASSERT_IMP(label, clk, rst, ante, cons)
`define LLF_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

/* rtl/llf_pkg.sv */
// Package for the ladder low-pass filter: widths, codes and the tanh table.
`default_nettype none

package llf_pkg;

  // Structure
  localparam int STAGES       = 4;
  localparam int STG_AW       = (STAGES > 1) ? $clog2(STAGES) : 1;
  localparam int TANH_DEPTH   = 1024;
  localparam int TANH_AW      = $clog2(TANH_DEPTH + 1);
  localparam int TANH_W       = 22;
  localparam int TAYLOR_TERMS = 20;
  localparam int MAX_WHOLE    = 8;   // t spans [0, 8]

  // Datapath widths
  localparam int IN_W      = 16;
  localparam int X_SHIFT   = 6;
  localparam int X_W       = IN_W + X_SHIFT;
  localparam int S_W       = 24;
  localparam int GAIN_W    = 16;
  localparam int CFG_W     = 17;
  localparam int COEF_W    = 16;
  localparam int GX_W      = 20;
  localparam int MA_W      = 22;
  localparam int MB_W      = 25;
  localparam int P_W       = MA_W + MB_W;
  localparam int DIFF_W    = 41;
  localparam int DIFF_LO_W = 20;
  localparam int DIFF_HI_W = DIFF_W - DIFF_LO_W;
  localparam int YL_SHIFT  = 16;
  localparam int FB_W      = 59;
  localparam int FB_SHIFT  = 30;
  localparam int FB_V_W    = FB_W - FB_SHIFT;
  localparam int U_W       = 30;
  localparam int U_FRAC    = 21;
  localparam int TANH_IDX_SHIFT = U_FRAC + 2;
  localparam int IDX_SC_W  = U_W + TANH_AW + 1;
  localparam int IDX_SH_W  = IDX_SC_W - TANH_IDX_SHIFT;
  localparam int ACC_W     = 44;
  localparam int ACC_SHIFT = 16;
  localparam int Y_W       = ACC_W - ACC_SHIFT;
  localparam int OUT_SHIFT = 6;
  localparam int OSUM_W    = S_W + 1;
  localparam int OW_W      = OSUM_W - OUT_SHIFT;

  // Reciprocal of 13: floor(n/13) = (n * RECIP13) >> RECIP13_SHIFT for n < 2^20
  localparam int RECIP13_SHIFT = 24;
  localparam logic [20:0] RECIP13 =
    21'(((64'd1 << RECIP13_SHIFT) + 64'd12) / 64'd13);

  // Register reset values
  localparam logic [GAIN_W-1:0] GAIN_RST = 16'd1716;
  localparam logic [CFG_W-1:0]  RES_RST  = 17'd0;
  localparam logic [CFG_W-1:0]  COMP_RST = 17'd32768;

  // Register indexes
  localparam logic [1:0] REG_STAGE_GAIN = 2'd0;
  localparam logic [1:0] REG_RESONANCE  = 2'd1;
  localparam logic [1:0] REG_GAIN_COMP  = 2'd2;

  // Sequencer states
  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_PREP  = 5'b00010,
    ST_RUN   = 5'b00100,
    ST_DRAIN = 5'b01000,
    ST_EMIT  = 5'b10000
  } state_t;

  // What to do with a product when it lands
  typedef enum logic [3:0] {
    OP_NONE,
    OP_CX,
    OP_B0,
    OP_B1,
    OP_FBLO,
    OP_FBHI,
    OP_ACC_FIRST,
    OP_ACC_ADD,
    OP_ACC_LAST
  } op_t;

  typedef logic [TANH_DEPTH:0][TANH_W-1:0] tanh_rom_t;

  localparam logic [63:0] ONE_Q30  = 64'd1 << 30;
  localparam logic [63:0] EINV_Q30 = 64'd395007542;

  // Restoring long division, elaboration use only
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] quo;
    logic [64:0] rem;
    quo = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem = rem - {1'b0, den};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // tanh(t/2) over t in [0, 8], Q.21, via e^-t in Q30
  function automatic tanh_rom_t build_tanh();
    tanh_rom_t   rom;
    logic [63:0] t;
    logic [63:0] whole;
    logic [63:0] frac;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] e;
    rom = '0;
    for (int k = 0; k <= TANH_DEPTH; k++) begin
      t     = udiv64(64'(k) << 33, 64'(TANH_DEPTH));
      whole = t >> 30;
      frac  = t & (ONE_Q30 - 64'd1);
      term  = ONE_Q30;
      sum   = ONE_Q30;
      for (int i = 1; i <= TAYLOR_TERMS; i++) begin
        term = udiv64((term * frac) >> 30, 64'(i));
        if (i[0]) begin
          sum = sum - term;
        end else begin
          sum = sum + term;
        end
      end
      e = sum;
      for (int j = 0; j < MAX_WHOLE; j++) begin
        if (64'(j) < whole) begin
          e = (e * EINV_Q30 + (ONE_Q30 >> 1)) >> 30;
        end
      end
      rom[k] = TANH_W'(udiv64(((ONE_Q30 - e) << 21) + ((ONE_Q30 + e) >> 1), ONE_Q30 + e));
    end
    return rom;
  endfunction

  localparam tanh_rom_t TANH_ROM = build_tanh();

endpackage

`default_nettype wire

/* rtl/ladder_lowpass_filter.sv */
// Top level of the ladder low-pass filter: sequencer, shared multiplier and state.
//
// Usage:
//   s_axis carries one Q1.15 audio sample per beat; m_axis returns one filtered
//   Q1.15 sample per input beat, with tuser[0] set when the output clamp hit.
//   The cfg channel writes stage_gain (index 0), resonance_amount (index 1) and
//   gain_compensation (index 2); other indexes are dropped. cfg_ready is always
//   high; write only while no sample is in flight.
// Timing:
//   One 22x25 signed multiplier does every product: the coefficient divides by
//   13, the feedback products and three products per stage. A new sample is
//   taken only after the sequencer is done with the previous one and is back
//   in idle: s_axis_tready is high only while the sequencer is idle.
// Reset:
//   rst (synchronous, active high) restores the register defaults, clears the
//   per-stage history and drops any pending result.
// Stall:
//   The result register frees the input side: the next sample is accepted
//   while a result waits; that sample then holds in its final step until
//   m_axis_tready takes the waiting beat.
`default_nettype none
`include "ladder_lowpass_filter_macros.svh"

module ladder_lowpass_filter
  import llf_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  // Input samples
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  input  wire logic [15:0]       s_axis_tdata,   // [15:0] sample_in
  // Filtered samples
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  output logic [15:0]            m_axis_tdata,   // [15:0] sample_out
  output logic [0:0]             m_axis_tuser,   // [0] clipped
  // Register writes
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [CFG_W-1:0]  cfg_data
);

  // Sequencer
  state_t              state;
  state_t              state_next;
  logic [2:0]          step;
  logic [1:0]          phase;
  logic [STG_AW-1:0]   stage_idx;

  localparam logic [2:0]        PREP_LAST  = 3'd7;
  localparam logic [2:0]        DRAIN_LAST = 3'd1;
  localparam logic [1:0]        PH_LAST    = 2'd2;
  localparam logic [STG_AW-1:0] LAST_STAGE = STG_AW'(STAGES - 1);

  // Registers
  logic [GAIN_W-1:0]   stage_gain;
  logic [CFG_W-1:0]    resonance_amount;
  logic [CFG_W-1:0]    gain_compensation;

  // Datapath
  logic signed [X_W-1:0]    x;
  logic [COEF_W-1:0]        b0;
  logic [COEF_W-1:0]        b1;
  logic [CFG_W-1:0]         a_coef;
  logic [GX_W-1:0]          gain_x10;
  logic [GX_W-1:0]          gain_x3;
  logic signed [MA_W-1:0]   mul_a;
  logic signed [MB_W-1:0]   mul_b;
  op_t                      issue_op;
  logic signed [P_W-1:0]    prod;
  op_t                      prod_op;
  logic [STG_AW-1:0]        prod_stage;
  logic signed [DIFF_W-1:0] diff;
  logic signed [DIFF_W-1:0] ylast_ext;
  logic signed [FB_W-1:0]   fbacc;
  logic signed [FB_W-1:0]   fb_sum;
  logic signed [FB_V_W-1:0] fb_val;
  logic signed [U_W-1:0]    u;
  logic [U_W-1:0]           mag;
  logic [IDX_SC_W-1:0]      idx_scaled;
  logic [IDX_SH_W-1:0]      idx_shift;
  logic [TANH_AW-1:0]       idx;
  logic                     neg;
  logic [TANH_W-1:0]        rom_q;
  logic signed [S_W-1:0]    rom_ext;
  logic signed [S_W-1:0]    cur_s;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  acc_rnd;
  logic signed [Y_W-1:0]    y_wide;
  logic signed [S_W-1:0]    y_sat;
  logic [3:0]               pre_pipe;
  logic                     fin;
  logic [STG_AW-1:0]        fin_stage;
  logic signed [S_W-1:0]    xprev [STAGES];
  logic signed [S_W-1:0]    yprev [STAGES];
  logic signed [OSUM_W-1:0] out_sum;
  logic signed [OW_W-1:0]   out_wide;
  logic [IN_W-1:0]          out_val;
  logic                     out_clip;
  logic                     emit_load;

  assign s_axis_tready = (state == ST_IDLE);
  assign cfg_ready     = 1'b1;
  assign emit_load     = (state == ST_EMIT) && (!m_axis_tvalid || m_axis_tready);

  // Coefficient numerators: b0 = (10g+6)/13, b1 = (3g+6)/13; pole a = 1 - g
  assign gain_x10 = ({4'b0, stage_gain} << 3) + ({4'b0, stage_gain} << 1) + GX_W'(6);
  assign gain_x3  = ({4'b0, stage_gain} << 1) + {4'b0, stage_gain} + GX_W'(6);
  assign a_coef   = {1'b1, {GAIN_W{1'b0}}} - {1'b0, stage_gain};

  // ---------------------------------------------------------------------------
  // Register writes
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_gain        <= GAIN_RST;
      resonance_amount  <= RES_RST;
      gain_compensation <= COMP_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_STAGE_GAIN: stage_gain        <= cfg_data[GAIN_W-1:0];
        REG_RESONANCE:  resonance_amount  <= cfg_data;
        REG_GAIN_COMP:  gain_compensation <= cfg_data;
        default: ;  // drop writes to unused indexes
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer: PREP issues the coefficient and feedback products, RUN walks
  // the stages three products each, DRAIN lets the last stage land, EMIT
  // forms the output once the result register is free.
  // ---------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (s_axis_tvalid) state_next = ST_PREP;
      ST_PREP:  if (step == PREP_LAST) state_next = ST_RUN;
      ST_RUN:   if (phase == PH_LAST && stage_idx == LAST_STAGE) state_next = ST_DRAIN;
      ST_DRAIN: if (step == DRAIN_LAST) state_next = ST_EMIT;
      ST_EMIT:  if (!m_axis_tvalid || m_axis_tready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step      <= '0;
      phase     <= '0;
      stage_idx <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        ST_IDLE: begin
          step <= '0;
        end
        ST_PREP: begin
          step      <= step + 3'd1;
          phase     <= '0;
          stage_idx <= '0;
        end
        ST_RUN: begin
          step <= '0;
          if (phase == PH_LAST) begin
            phase     <= '0;
            stage_idx <= stage_idx + STG_AW'(1);
          end else begin
            phase <= phase + 2'd1;
          end
        end
        ST_DRAIN: begin
          step <= step + 3'd1;
        end
        ST_EMIT: ;
        default: ;
      endcase
    end
  end

  // Latch the sample, scaled to Q1.21
  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      x <= {s_axis_tdata, {X_SHIFT{1'b0}}};
    end
  end

  // ---------------------------------------------------------------------------
  // Multiplier operand selection
  // ---------------------------------------------------------------------------
  always_comb begin
    mul_a    = '0;
    mul_b    = '0;
    issue_op = OP_NONE;
    if (state == ST_PREP) begin
      unique case (step)
        3'd0: begin
          mul_a    = {5'b0, gain_compensation};
          mul_b    = {{(MB_W-X_W){x[X_W-1]}}, x};
          issue_op = OP_CX;
        end
        3'd1: begin
          mul_a    = {1'b0, RECIP13};
          mul_b    = {5'b0, gain_x10};
          issue_op = OP_B0;
        end
        3'd2: begin
          mul_a    = {1'b0, RECIP13};
          mul_b    = {5'b0, gain_x3};
          issue_op = OP_B1;
        end
        3'd3: begin
          mul_a    = {5'b0, resonance_amount};
          mul_b    = {5'b0, diff[DIFF_LO_W-1:0]};
          issue_op = OP_FBLO;
        end
        3'd4: begin
          mul_a    = {5'b0, resonance_amount};
          mul_b    = {{(MB_W-DIFF_HI_W){diff[DIFF_W-1]}}, diff[DIFF_W-1:DIFF_LO_W]};
          issue_op = OP_FBHI;
        end
        default: ;  // wait for the tanh lookup
      endcase
    end else if (state == ST_RUN) begin
      unique case (phase)
        2'd0: begin
          mul_a    = {5'b0, a_coef};
          mul_b    = {yprev[stage_idx][S_W-1], yprev[stage_idx]};
          issue_op = OP_ACC_FIRST;
        end
        2'd1: begin
          mul_a    = {6'b0, b1};
          mul_b    = {xprev[stage_idx][S_W-1], xprev[stage_idx]};
          issue_op = OP_ACC_ADD;
        end
        2'd2: begin
          mul_a    = {6'b0, b0};
          mul_b    = {cur_s[S_W-1], cur_s};
          issue_op = OP_ACC_LAST;
        end
        default: ;
      endcase
    end
  end

  // Shared multiplier, registered
  always_ff @(posedge clk) begin
    prod       <= mul_a * mul_b;
    prod_stage <= stage_idx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_op  <= OP_NONE;
      pre_pipe <= '0;
      fin      <= 1'b0;
    end else begin
      prod_op  <= issue_op;
      pre_pipe <= {pre_pipe[2:0], prod_op == OP_FBHI};
      fin      <= (prod_op == OP_ACC_LAST);
    end
  end

  // ---------------------------------------------------------------------------
  // Product writeback
  // ---------------------------------------------------------------------------
  assign ylast_ext = {{(DIFF_W-S_W-YL_SHIFT){yprev[STAGES-1][S_W-1]}}, yprev[STAGES-1],
                      {YL_SHIFT{1'b0}}};

  always_ff @(posedge clk) begin
    case (prod_op)
      OP_CX:   diff <= ylast_ext - prod[DIFF_W-1:0];
      OP_B0:   b0   <= prod[RECIP13_SHIFT +: COEF_W];
      OP_B1:   b1   <= prod[RECIP13_SHIFT +: COEF_W];
      OP_FBLO: fbacc <= {{(FB_W-P_W){prod[P_W-1]}}, prod};
      OP_FBHI: fbacc <= fbacc + ({{(FB_W-P_W){prod[P_W-1]}}, prod} <<< DIFF_LO_W);
      OP_ACC_FIRST: acc <= prod[ACC_W-1:0];
      OP_ACC_ADD, OP_ACC_LAST: begin
        acc <= acc + prod[ACC_W-1:0];
      end
      default: ;
    endcase
    if (prod_op == OP_ACC_LAST) begin
      fin_stage <= prod_stage;
    end
  end

  // ---------------------------------------------------------------------------
  // Feedback and tanh lookup: round feedback, index the table, apply sign
  // ---------------------------------------------------------------------------
  assign fb_sum = fbacc + (FB_W'(1) <<< (FB_SHIFT - 1));
  assign fb_val = fb_sum[FB_W-1:FB_SHIFT];

  assign mag        = u[U_W-1] ? U_W'(-u) : U_W'(u);
  assign idx_scaled = IDX_SC_W'(mag) * IDX_SC_W'(TANH_DEPTH)
                    + (IDX_SC_W'(1) << (TANH_IDX_SHIFT - 1));
  assign idx_shift  = idx_scaled[IDX_SC_W-1:TANH_IDX_SHIFT];
  assign rom_ext    = {{(S_W-TANH_W){1'b0}}, rom_q};

  always_ff @(posedge clk) begin
    if (pre_pipe[0]) begin
      u <= {{(U_W-X_W){x[X_W-1]}}, x} - {fb_val[FB_V_W-1], fb_val};
    end
    if (pre_pipe[1]) begin
      neg <= u[U_W-1];
      // Clamp past the table end to the last entry
      if (idx_shift > IDX_SH_W'(TANH_DEPTH)) begin
        idx <= TANH_AW'(TANH_DEPTH);
      end else begin
        idx <= idx_shift[TANH_AW-1:0];
      end
    end
    if (pre_pipe[2]) begin
      rom_q <= TANH_ROM[idx];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage result: round half up, saturate to 24 bits, advance history
  // ---------------------------------------------------------------------------
  assign acc_rnd = acc + (ACC_W'(1) <<< (ACC_SHIFT - 1));
  assign y_wide  = acc_rnd[ACC_W-1:ACC_SHIFT];

  always_comb begin
    if ((&y_wide[Y_W-1:S_W-1]) || !(|y_wide[Y_W-1:S_W-1])) begin
      y_sat = y_wide[S_W-1:0];
    end else if (y_wide[Y_W-1]) begin
      y_sat = {1'b1, {(S_W-1){1'b0}}};
    end else begin
      y_sat = {1'b0, {(S_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (pre_pipe[3]) begin
      cur_s <= neg ? -rom_ext : rom_ext;
    end else if (fin) begin
      cur_s <= y_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < STAGES; i++) begin
        xprev[i] <= '0;
        yprev[i] <= '0;
      end
    end else if (fin) begin
      xprev[fin_stage] <= cur_s;
      yprev[fin_stage] <= y_sat;
    end
  end

  // ---------------------------------------------------------------------------
  // Output: round to Q1.15, clamp, hold until taken
  // ---------------------------------------------------------------------------
  assign out_sum  = {cur_s[S_W-1], cur_s} + OSUM_W'(32);
  assign out_wide = out_sum[OSUM_W-1:OUT_SHIFT];

  always_comb begin
    out_clip = 1'b0;
    out_val  = out_wide[IN_W-1:0];
    if (!((&out_wide[OW_W-1:IN_W-1]) || !(|out_wide[OW_W-1:IN_W-1]))) begin
      out_clip = 1'b1;
      out_val  = out_wide[OW_W-1] ? {1'b1, {(IN_W-1){1'b0}}} : {1'b0, {(IN_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (emit_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_load) begin
      m_axis_tdata    <= out_val;
      m_axis_tuser[0] <= out_clip;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // The tanh result and a stage result never both write cur_s
  `LLF_ASSERT_IMP(a_tanh_vs_fin, clk, rst, pre_pipe[3], !fin)
  // A stage closes only from the third product slot of RUN
  `LLF_ASSERT_IMP(a_last_from_run, clk, rst, prod_op == OP_ACC_LAST,
                  $past(state == ST_RUN && phase == PH_LAST))
  // Output forms only after every product and stage update has landed
  `LLF_ASSERT_IMP(a_emit_drained, clk, rst, state == ST_EMIT,
                  !fin && prod_op == OP_NONE && pre_pipe == 4'b0)

endmodule

`default_nettype wire
